// ----- src/skvt_pkg.sv -----
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared constants, codes and types of the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int CAPACITY   = 16;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;

  localparam int IDX_BITS = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_BITS = $clog2(CAPACITY + 1);

  localparam int CMD_BITS    = 3;
  localparam int FIELD_BITS  = 32;
  localparam int STATUS_BITS = 2;
  localparam int COUNT_BITS  = 5;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_INSERT = 3'd0,
    CMD_LOOKUP = 3'd1,
    CMD_MIN    = 3'd2,
    CMD_MAX    = 3'd3,
    CMD_SCAN   = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_MISS  = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic                  we;
    logic [IDX_BITS-1:0]   addr;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } skvt_wr_t;

  typedef struct packed {
    logic ge_lo;
    logic le_hi;
    logic eq;
  } skvt_cmp_t;

endpackage

// ----- src/sorted_key_value_table.sv -----
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Key-sorted table of up to CAPACITY key/value pairs with insert, lookup,
// minimum, maximum and range scan. A transaction is taken when start_i is
// high and busy_o is low. Results come one per cycle on the result ports,
// each marked by a single-cycle result_valid_o strobe, and cannot be held
// off; last_o marks the final result of a transaction. A refused insert into
// a full table and a lookup, minimum, maximum or range scan of an empty table
// finish on acceptance without going busy; minimum and maximum otherwise read
// the end entry in S_PEEK. All other work walks the table one entry per cycle
// through a single registered store read port, addressed from the next index,
// and one shared comparator: insert walks down from the end shifting larger
// entries up, lookup walks until the first equal key or the end, and a range
// scan walks every entry, then gives a final result carrying the match count.
// Unused command codes are dropped without a result.
// ----------------------------------------------------------------------------
module sorted_key_value_table (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [skvt_pkg::CMD_BITS-1:0]       cmd_i,
  input  logic [skvt_pkg::FIELD_BITS-1:0]     key_i,
  input  logic [skvt_pkg::FIELD_BITS-1:0]     value_i,
  input  logic [skvt_pkg::FIELD_BITS-1:0]     key_upper_i,
  output logic                                result_valid_o,
  output logic [skvt_pkg::STATUS_BITS-1:0]    status_o,
  output logic [skvt_pkg::FIELD_BITS-1:0]     out_key_o,
  output logic [skvt_pkg::FIELD_BITS-1:0]     out_value_o,
  output logic [skvt_pkg::COUNT_BITS-1:0]     count_o,
  output logic                                last_o
);
  import skvt_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PEEK   = 6'b000010,
    S_INSERT = 6'b000100,
    S_LOOKUP = 6'b001000,
    S_SCAN   = 6'b010000,
    S_FINAL  = 6'b100000
  } state_e;

  state_e                state_q, state_d;
  logic [IDX_BITS-1:0]   idx_q, idx_d;
  logic [CNT_BITS-1:0]   count_q, count_d;
  logic [CNT_BITS-1:0]   scan_q, scan_d;

  logic [KEY_BITS-1:0]   lo_q, hi_q;
  logic [VALUE_BITS-1:0] val_q;

  logic [IDX_BITS-1:0]   rd_addr;
  logic [KEY_BITS+VALUE_BITS-1:0] rd_data;
  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;
  skvt_wr_t              wr;
  skvt_cmp_t             cmp;

  logic                  accept;
  logic                  shift;
  logic                  at_end;
  logic [IDX_BITS-1:0]   last_idx;

  logic                  emit;
  logic [STATUS_BITS-1:0] e_status;
  logic [FIELD_BITS-1:0] e_key;
  logic [FIELD_BITS-1:0] e_value;
  logic [COUNT_BITS-1:0] e_count;
  logic                  e_last;

  logic                  res_valid_q;
  logic [STATUS_BITS-1:0] status_q;
  logic [FIELD_BITS-1:0] out_key_q;
  logic [FIELD_BITS-1:0] out_value_q;
  logic [COUNT_BITS-1:0] out_count_q;
  logic                  last_q;

  skvt_store #(
    .WIDTH (KEY_BITS + VALUE_BITS),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr.we),
    .waddr_i (wr.addr),
    .wdata_i ({wr.key, wr.value}),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  assign rd_key   = rd_data[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
  assign rd_value = rd_data[VALUE_BITS-1:0];

  skvt_cmp u_cmp (
    .entry_key_i (rd_key),
    .lo_i        (lo_q),
    .hi_i        (hi_q),
    .res_o       (cmp)
  );

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign last_idx = IDX_BITS'(count_q - 1'b1);
  assign at_end   = (idx_q == last_idx);
  assign shift    = (idx_q != '0) && !cmp.le_hi;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    count_d  = count_q;
    scan_d   = scan_q;
    wr       = '0;
    emit     = 1'b0;
    e_status = ST_OK;
    e_key    = '0;
    e_value  = '0;
    e_count  = '0;
    e_last   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i) inside
            CMD_INSERT: begin
              if (count_q == CNT_BITS'(CAPACITY)) begin
                emit     = 1'b1;
                e_status = ST_FULL;
                e_key    = FIELD_BITS'(KEY_BITS'(key_i));
                e_value  = FIELD_BITS'(VALUE_BITS'(value_i));
                e_count  = COUNT_BITS'(CAPACITY);
              end else begin
                idx_d   = IDX_BITS'(count_q);
                state_d = S_INSERT;
              end
            end
            CMD_LOOKUP: begin
              if (count_q == '0) begin
                emit     = 1'b1;
                e_status = ST_MISS;
                e_key    = FIELD_BITS'(KEY_BITS'(key_i));
              end else begin
                idx_d   = '0;
                state_d = S_LOOKUP;
              end
            end
            CMD_MIN, CMD_MAX: begin
              if (count_q == '0) begin
                emit     = 1'b1;
                e_status = ST_MISS;
              end else begin
                idx_d   = (cmd_i == CMD_MAX) ? last_idx : '0;
                state_d = S_PEEK;
              end
            end
            CMD_SCAN: begin
              idx_d  = '0;
              scan_d = '0;
              if (count_q == '0) begin
                emit = 1'b1;
              end else begin
                state_d = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_PEEK: begin
        emit    = 1'b1;
        e_key   = FIELD_BITS'(rd_key);
        e_value = FIELD_BITS'(rd_value);
        e_count = COUNT_BITS'(count_q);
        state_d = S_IDLE;
      end
      S_INSERT: begin
        wr.we   = 1'b1;
        wr.addr = idx_q;
        if (shift) begin
          wr.key   = rd_key;
          wr.value = rd_value;
          idx_d    = idx_q - 1'b1;
        end else begin
          wr.key   = lo_q;
          wr.value = val_q;
          count_d  = count_q + 1'b1;
          emit     = 1'b1;
          e_key    = FIELD_BITS'(lo_q);
          e_value  = FIELD_BITS'(val_q);
          e_count  = COUNT_BITS'(count_q + 1'b1);
          state_d  = S_IDLE;
        end
      end
      S_LOOKUP: begin
        if (cmp.eq) begin
          emit    = 1'b1;
          e_key   = FIELD_BITS'(rd_key);
          e_value = FIELD_BITS'(rd_value);
          e_count = COUNT_BITS'(count_q);
          state_d = S_IDLE;
        end else if (at_end) begin
          emit     = 1'b1;
          e_status = ST_MISS;
          e_key    = FIELD_BITS'(lo_q);
          e_count  = COUNT_BITS'(count_q);
          state_d  = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SCAN: begin
        if (cmp.ge_lo && cmp.le_hi) begin
          emit    = 1'b1;
          e_key   = FIELD_BITS'(rd_key);
          e_value = FIELD_BITS'(rd_value);
          e_count = COUNT_BITS'(count_q);
          e_last  = 1'b0;
          scan_d  = scan_q + 1'b1;
        end
        if (at_end) begin
          state_d = S_FINAL;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FINAL: begin
        emit    = 1'b1;
        e_count = COUNT_BITS'(scan_q);
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // registered read of the next index, or the one below it on insert
    rd_addr = (state_d == S_INSERT) ? idx_d - 1'b1 : idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      count_q     <= '0;
      scan_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      res_valid_q <= emit;
    end
  end

  // transaction operands and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      lo_q  <= KEY_BITS'(key_i);
      hi_q  <= (cmd_i == CMD_INSERT) ? KEY_BITS'(key_i) : KEY_BITS'(key_upper_i);
      val_q <= VALUE_BITS'(value_i);
    end
    if (emit) begin
      status_q    <= e_status;
      out_key_q   <= e_key;
      out_value_q <= e_value;
      out_count_q <= e_count;
      last_q      <= e_last;
    end
  end

  assign result_valid_o = res_valid_q;
  assign status_o       = status_q;
  assign out_key_o      = out_key_q;
  assign out_value_o    = out_value_q;
  assign count_o        = out_count_q;
  assign last_o         = last_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(CAPACITY))
    else $error("entry count beyond capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INSERT && !shift) |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not add one entry");

  a_final_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL) |=> (result_valid_o && last_o))
    else $error("scan ended without a final result");

  a_scan_entry_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_o) |-> busy_o)
    else $error("scan entry emitted outside a scan");
`endif

endmodule

// ----- src/skvt_store.sv -----
// ----------------------------------------------------------------------------
// skvt_store
// Generic RAM: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skvt_store #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/skvt_cmp.sv -----
// ----------------------------------------------------------------------------
// skvt_cmp
// Shared key comparator: entry key against lower and upper reference keys.
// ----------------------------------------------------------------------------
module skvt_cmp (
  input  logic [skvt_pkg::KEY_BITS-1:0] entry_key_i,
  input  logic [skvt_pkg::KEY_BITS-1:0] lo_i,
  input  logic [skvt_pkg::KEY_BITS-1:0] hi_i,
  output skvt_pkg::skvt_cmp_t           res_o
);
  import skvt_pkg::*;

  assign res_o.ge_lo = (entry_key_i >= lo_i);
  assign res_o.le_hi = (entry_key_i <= hi_i);
  assign res_o.eq    = (entry_key_i == lo_i);

endmodule

// ----- tb/sorted_key_value_table_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_value_table_tb
// Drives insert, lookup, minimum, maximum, range scan and unused-code
// transactions into the table with random gaps and checks every result
// strobe in order against a small scoreboard's predicted sorted table.
// ----------------------------------------------------------------------------
module sorted_key_value_table_tb;
  import skvt_pkg::*;

  localparam int                  CYCLE_LIMIT    = 200000;
  localparam int                  DRAIN_CYCLES   = 2 * CAPACITY + 8;
  localparam int                  RANDOM_ITEMS   = 190;
  localparam int                  REPORT_LIMIT   = 10;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED_LO  = 3'd5;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED_MID = 3'd6;
  localparam logic [CMD_BITS-1:0] CMD_UNUSED_HI  = 3'd7;
  localparam logic [31:0]         KEY_TOP        = 32'hFFFF_FFFF;

  typedef struct {
    status_e                 status;
    logic [FIELD_BITS-1:0]   key;
    logic [FIELD_BITS-1:0]   value;
    logic [COUNT_BITS-1:0]   count;
    logic                    last;
  } table_result_t;

  class table_scoreboard;
    logic [KEY_BITS-1:0]   key_tbl[CAPACITY];
    logic [VALUE_BITS-1:0] value_tbl[CAPACITY];
    int                    fill;
    table_result_t         pending[$];
    int                    mismatches;

    function void queue_result(status_e st, logic [FIELD_BITS-1:0] k,
                               logic [FIELD_BITS-1:0] v, int cnt, logic fin);
      table_result_t r;
      r.status = st;
      r.key    = k;
      r.value  = v;
      r.count  = cnt[COUNT_BITS-1:0];
      r.last   = fin;
      pending.push_back(r);
    endfunction

    // predicts the results of one accepted transaction and updates the table
    function void note_txn(logic [CMD_BITS-1:0] cmd, logic [FIELD_BITS-1:0] k,
                           logic [FIELD_BITS-1:0] v, logic [FIELD_BITS-1:0] hi);
      int pos;
      int hits;
      case (cmd)
        CMD_INSERT: begin
          if (fill >= CAPACITY) begin
            queue_result(ST_FULL, k, v, CAPACITY, 1'b1);
          end else begin
            pos = fill;
            while (pos > 0 && key_tbl[pos-1] > k) begin
              key_tbl[pos]   = key_tbl[pos-1];
              value_tbl[pos] = value_tbl[pos-1];
              pos--;
            end
            key_tbl[pos]   = k;
            value_tbl[pos] = v;
            fill++;
            queue_result(ST_OK, k, v, fill, 1'b1);
          end
        end
        CMD_LOOKUP: begin
          pos = -1;
          for (int i = fill - 1; i >= 0; i--)
            if (key_tbl[i] == k) pos = i;
          if (pos >= 0) queue_result(ST_OK, key_tbl[pos], value_tbl[pos], fill, 1'b1);
          else queue_result(ST_MISS, k, '0, fill, 1'b1);
        end
        CMD_MIN, CMD_MAX: begin
          if (fill == 0) begin
            queue_result(ST_MISS, '0, '0, 0, 1'b1);
          end else begin
            pos = (cmd == CMD_MIN) ? 0 : fill - 1;
            queue_result(ST_OK, key_tbl[pos], value_tbl[pos], fill, 1'b1);
          end
        end
        CMD_SCAN: begin
          hits = 0;
          for (int i = 0; i < fill; i++) begin
            if (key_tbl[i] >= k && key_tbl[i] <= hi) begin
              queue_result(ST_OK, key_tbl[i], value_tbl[i], fill, 1'b0);
              hits++;
            end
          end
          queue_result(ST_OK, '0, '0, hits, 1'b1);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(logic [STATUS_BITS-1:0] st, logic [FIELD_BITS-1:0] k,
                               logic [FIELD_BITS-1:0] v, logic [COUNT_BITS-1:0] cnt,
                               logic fin);
      table_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: status %0d key %h value %h count %0d last %b",
                   st, k, v, cnt, fin);
        return;
      end
      want = pending.pop_front();
      if (st !== want.status || k !== want.key || v !== want.value ||
          cnt !== want.count || fin !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"result differs at %0t: expected status %0d key %h value %h ",
                    "count %0d last %b, got status %0d key %h value %h count %0d last %b"},
                   $time, want.status, want.key, want.value, want.count, want.last,
                   st, k, v, cnt, fin);
      end
    endfunction
  endclass

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    start_i     = 1'b0;
  logic [CMD_BITS-1:0]     cmd_i       = '0;
  logic [FIELD_BITS-1:0]   key_i       = '0;
  logic [FIELD_BITS-1:0]   value_i     = '0;
  logic [FIELD_BITS-1:0]   key_upper_i = '0;
  logic                    busy_o;
  logic                    result_valid_o;
  logic [STATUS_BITS-1:0]  status_o;
  logic [FIELD_BITS-1:0]   out_key_o;
  logic [FIELD_BITS-1:0]   out_value_o;
  logic [COUNT_BITS-1:0]   count_o;
  logic                    last_o;

  table_scoreboard         sb;
  logic [FIELD_BITS-1:0]   key_pool[8];
  bit                      gaps_on;
  int                      cycles;

  sorted_key_value_table u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .key_i          (key_i),
    .value_i        (value_i),
    .key_upper_i    (key_upper_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .out_key_o      (out_key_o),
    .out_value_o    (out_value_o),
    .count_o        (count_o),
    .last_o         (last_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // accepted transactions are noted before results of the same edge are checked
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o) sb.note_txn(cmd_i, key_i, value_i, key_upper_i);
    if (rst_ni && result_valid_o)
      sb.check_result(status_o, out_key_o, out_value_o, count_o, last_o);
  end

  task automatic issue_txn(logic [CMD_BITS-1:0] c, logic [FIELD_BITS-1:0] k,
                           logic [FIELD_BITS-1:0] v, logic [FIELD_BITS-1:0] hi);
    int gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    cmd_i       <= c;
    key_i       <= k;
    value_i     <= v;
    key_upper_i <= hi;
    do @(posedge clk_i); while (!(start_i && !busy_o));
  endtask

  function automatic logic [FIELD_BITS-1:0] pick_key();
    if ($urandom_range(0, 9) < 6) return key_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  initial begin
    int                    done;
    int                    sel;
    logic [FIELD_BITS-1:0] lo;
    logic [FIELD_BITS-1:0] hi;
    sb = new();
    key_pool[0] = '0;
    key_pool[1] = KEY_TOP;
    for (int i = 2; i < 8; i++) key_pool[i] = $urandom;
    gaps_on = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table
    issue_txn(CMD_MIN, $urandom, $urandom, $urandom);
    issue_txn(CMD_MAX, $urandom, $urandom, $urandom);
    issue_txn(CMD_LOOKUP, '0, $urandom, $urandom);
    issue_txn(CMD_SCAN, '0, $urandom, KEY_TOP);
    issue_txn(CMD_UNUSED_LO, $urandom, $urandom, $urandom);
    issue_txn(CMD_UNUSED_MID, $urandom, $urandom, $urandom);
    issue_txn(CMD_UNUSED_HI, $urandom, $urandom, $urandom);
    // extremes and equal keys
    issue_txn(CMD_INSERT, KEY_TOP, KEY_TOP, $urandom);
    issue_txn(CMD_INSERT, '0, '0, $urandom);
    issue_txn(CMD_INSERT, '0, 32'h5A5A_A5A5, $urandom);
    issue_txn(CMD_INSERT, 32'h8000_0000, 32'h1234_5678, $urandom);
    issue_txn(CMD_LOOKUP, '0, $urandom, $urandom);
    issue_txn(CMD_LOOKUP, KEY_TOP, $urandom, $urandom);
    issue_txn(CMD_LOOKUP, 32'h7FFF_FFFF, $urandom, $urandom);
    issue_txn(CMD_MIN, $urandom, $urandom, $urandom);
    issue_txn(CMD_MAX, $urandom, $urandom, $urandom);
    issue_txn(CMD_SCAN, '0, $urandom, KEY_TOP);
    issue_txn(CMD_SCAN, '0, $urandom, '0);
    issue_txn(CMD_SCAN, KEY_TOP, $urandom, '0);
    issue_txn(CMD_SCAN, 32'h0000_0001, $urandom, 32'hFFFF_FFFE);
    issue_txn(CMD_SCAN, KEY_TOP, $urandom, KEY_TOP);

    done = 0;
    while (done < RANDOM_ITEMS) begin
      if (done % 30 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
        issue_txn(CMD_INSERT, pick_key(), $urandom, $urandom);
      end else if (sel < 40) begin
        issue_txn(CMD_LOOKUP, pick_key(), $urandom, $urandom);
      end else if (sel < 53) begin
        issue_txn(CMD_MIN, $urandom, $urandom, $urandom);
      end else if (sel < 66) begin
        issue_txn(CMD_MAX, $urandom, $urandom, $urandom);
      end else if (sel < 95) begin
        lo = pick_key();
        hi = pick_key();
        if ($urandom_range(0, 4) == 0) begin
          lo = '0;
          hi = KEY_TOP;
        end
        issue_txn(CMD_SCAN, lo, $urandom, hi);
      end else begin
        issue_txn(3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), $urandom, $urandom,
                  $urandom);
        continue;
      end
      done++;
    end
    start_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/skvt_pkg.sv
src/skvt_store.sv
src/skvt_cmp.sv
src/sorted_key_value_table.sv
tb/sorted_key_value_table_tb.sv
